FILE: rtl/core/nopb_pkg.sv
package nopb_pkg;

    localparam int QUEUE_DEPTH = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_X         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAC_Y         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_A       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_B       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DENSITY_OFFSET = 3'd4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [6:0] WEIGHT_A_RESET = 7'd32;
    localparam logic [6:0] WEIGHT_B_RESET = 7'd20;

    localparam logic [5:0] BAYER [64] = '{
         0, 32,  8, 40,  2, 34, 10, 42,
        48, 16, 56, 24, 50, 18, 58, 26,
        12, 44,  4, 36, 14, 46,  6, 38,
        60, 28, 52, 20, 62, 30, 54, 22,
         3, 35, 11, 43,  1, 33,  9, 41,
        51, 19, 59, 27, 49, 17, 57, 25,
        15, 47,  7, 39, 13, 45,  5, 37,
        63, 31, 55, 23, 61, 29, 53, 21
    };

    // queue entry: a palette write or a palette read at a finished index
    typedef struct packed {
        logic        wr;
        logic [7:0]  addr;
        logic [15:0] data;
    } qitem_t;

    // (bayer - 31) / 4, rounded toward zero
    function automatic logic signed [4:0] dither_term(input logic [2:0] row,
                                                      input logic [2:0] col);
        logic signed [6:0] t;
        logic signed [6:0] adj;
        t   = $signed({1'b0, BAYER[{row, col}]}) - 7'sd31;
        adj = t[6] ? t + 7'sd3 : t;
        return adj[6:2];
    endfunction

endpackage

FILE: rtl/core/nopb_ifs.sv
interface nopb_pix_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  tex_a00;
    logic [7:0]  tex_a01;
    logic [7:0]  tex_a10;
    logic [7:0]  tex_a11;
    logic [7:0]  tex_b;
    logic [7:0]  tex_c;
    logic [2:0]  dither_col;
    logic [2:0]  dither_row;
    logic [7:0]  pal_index;
    logic [15:0] pal_color;

    modport source (
        output valid, func, tex_a00, tex_a01, tex_a10, tex_a11, tex_b, tex_c,
               dither_col, dither_row, pal_index, pal_color,
        input  ready
    );
    modport sink (
        input  valid, func, tex_a00, tex_a01, tex_a10, tex_a11, tex_b, tex_c,
               dither_col, dither_row, pal_index, pal_color,
        output ready
    );
endinterface

interface nopb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink (input valid, pixel_color, output ready);
endinterface

interface nopb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/nopb_front.sv
module nopb_front #(
    parameter int QDEPTH = nopb_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    nopb_pix_if.sink        pixel,
    nopb_cfg_if.sink        cfg,
    input  logic            pop,
    output logic            push,
    output nopb_pkg::qitem_t push_item
);
    import nopb_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 1);

    function automatic logic [7:0] lerp_q8(input logic [7:0] p,
                                           input logic [7:0] q,
                                           input logic [7:0] f);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [9:0]  sum;
        diff = $signed({1'b0, q}) - $signed({1'b0, p});
        prod = diff * $signed({1'b0, f});
        sum  = $signed({2'b00, p}) + $signed(prod[17:8]);
        return sum[7:0];
    endfunction

    logic [7:0]        frac_x_reg;
    logic [7:0]        frac_y_reg;
    logic [6:0]        weight_a_reg;
    logic [6:0]        weight_b_reg;
    logic signed [6:0] density_offset_reg;

    logic [CNT_W-1:0]  credit_reg;
    logic [CNT_W-1:0]  credit_next;
    logic              accept;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;

    logic              s1_func_reg;
    logic [7:0]        s1_va_reg;
    logic [7:0]        s1_vb_reg;
    logic [7:0]        s1_b_reg;
    logic [7:0]        s1_c_reg;
    logic signed [4:0] s1_d_reg;
    logic [7:0]        s1_idx_reg;
    logic [15:0]       s1_color_reg;

    logic              s2_func_reg;
    logic [7:0]        s2_a_reg;
    logic [7:0]        s2_b_reg;
    logic [7:0]        s2_c_reg;
    logic signed [4:0] s2_d_reg;
    logic [7:0]        s2_idx_reg;
    logic [15:0]       s2_color_reg;

    logic              s3_func_reg;
    logic signed [17:0] s3_mix_reg;
    logic [7:0]        s3_c_reg;
    logic signed [4:0] s3_d_reg;
    logic [7:0]        s3_idx_reg;
    logic [15:0]       s3_color_reg;

    logic signed [8:0]  diff_a;
    logic signed [8:0]  diff_b;
    logic signed [16:0] prod_a;
    logic signed [16:0] prod_b;
    logic signed [17:0] mix_next;
    logic signed [13:0] v_sum;
    logic [7:0]         v_clamped;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_reg         <= '0;
            frac_y_reg         <= '0;
            weight_a_reg       <= WEIGHT_A_RESET;
            weight_b_reg       <= WEIGHT_B_RESET;
            density_offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FRAC_X:         frac_x_reg         <= cfg.data;
                CFG_FRAC_Y:         frac_y_reg         <= cfg.data;
                CFG_WEIGHT_A:       weight_a_reg       <= cfg.data[6:0];
                CFG_WEIGHT_B:       weight_b_reg       <= cfg.data[6:0];
                CFG_DENSITY_OFFSET: density_offset_reg <= $signed(cfg.data[6:0]);
                default:            ;
            endcase
        end
    end

    // credits cover every item from its transfer until the back end pops it
    assign pixel.ready = (credit_reg < CNT_W'(QDEPTH));
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
            credit_next = credit_reg + 1'b1;
        else if (!accept && pop)
            credit_next = credit_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // mix of the three octaves
    assign diff_a   = $signed({1'b0, s2_a_reg}) - $signed({1'b0, s2_c_reg});
    assign diff_b   = $signed({1'b0, s2_b_reg}) - $signed({1'b0, s2_c_reg});
    assign prod_a   = diff_a * $signed({1'b0, weight_a_reg});
    assign prod_b   = diff_b * $signed({1'b0, weight_b_reg});
    assign mix_next = 18'(prod_a) + 18'(prod_b);

    always_ff @(posedge clk)
    begin
        // stage 1: interpolate along x
        s1_func_reg  <= pixel.func;
        s1_va_reg    <= lerp_q8(pixel.tex_a00, pixel.tex_a01, frac_x_reg);
        s1_vb_reg    <= lerp_q8(pixel.tex_a10, pixel.tex_a11, frac_x_reg);
        s1_b_reg     <= pixel.tex_b;
        s1_c_reg     <= pixel.tex_c;
        s1_d_reg     <= dither_term(pixel.dither_row, pixel.dither_col);
        s1_idx_reg   <= pixel.pal_index;
        s1_color_reg <= pixel.pal_color;

        // stage 2: interpolate along y
        s2_func_reg  <= s1_func_reg;
        s2_a_reg     <= lerp_q8(s1_va_reg, s1_vb_reg, frac_y_reg);
        s2_b_reg     <= s1_b_reg;
        s2_c_reg     <= s1_c_reg;
        s2_d_reg     <= s1_d_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_color_reg <= s1_color_reg;

        // stage 3: weighted mix
        s3_func_reg  <= s2_func_reg;
        s3_mix_reg   <= mix_next;
        s3_c_reg     <= s2_c_reg;
        s3_d_reg     <= s2_d_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_color_reg <= s2_color_reg;
    end

    // floor shift by 6, add dither and offset, clamp to the palette range
    assign v_sum = $signed({6'b0, s3_c_reg}) + 14'($signed(s3_mix_reg[17:6]))
                 + 14'(s3_d_reg) + 14'(density_offset_reg);

    always_comb
    begin
        priority if (v_sum[13])
            v_clamped = 8'd0;
        else if (|v_sum[12:8])
            v_clamped = 8'd255;
        else
            v_clamped = v_sum[7:0];
    end

    assign push           = s3_valid_reg;
    assign push_item.wr   = (s3_func_reg == FUNC_WRITE);
    assign push_item.addr = (s3_func_reg == FUNC_WRITE) ? s3_idx_reg : v_clamped;
    assign push_item.data = s3_color_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CNT_W'(QDEPTH))
        else $error("credit count above queue depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg >= CNT_W'({1'b0, s1_valid_reg} + {1'b0, s2_valid_reg}
                             + {1'b0, s3_valid_reg}))
        else $error("credit count below items in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !accept |=> credit_reg == $past(credit_reg) - 1'b1)
        else $error("credit not returned on pop");
`endif

endmodule

FILE: rtl/core/nopb_queue.sv
module nopb_queue #(
    parameter int DEPTH = nopb_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nopb_pkg::qitem_t push_item,
    input  logic             pop,
    output logic             head_valid,
    output nopb_pkg::qitem_t head_item
);
    import nopb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qitem_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && pop)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH)) || pop)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

FILE: rtl/core/nopb_back.sv
module nopb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  nopb_pkg::qitem_t head_item,
    output logic             pop,
    nopb_out_if.source       result
);
    import nopb_pkg::*;

    logic [15:0] pal_mem [256];
    logic [15:0] pal_q_reg;
    logic        rd_valid_reg;
    logic        rd_valid_next;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        rd_adv;

    // read stage moves to the output register when that is free or drains
    assign rd_adv = rd_valid_reg && (!out_valid_reg || result.ready);

    // writes never occupy the read stage
    assign pop = head_valid && (head_item.wr || !rd_valid_reg || rd_adv);

    assign rd_valid_next = (pop && !head_item.wr) || (rd_valid_reg && !rd_adv);

    always_ff @(posedge clk)
    begin
        if (pop && head_item.wr)
            pal_mem[head_item.addr] <= head_item.data;
        if (pop && !head_item.wr)
            pal_q_reg <= pal_mem[head_item.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
            if (rd_adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_adv)
            out_data_reg <= pal_q_reg;
    end

    assign result.valid       = out_valid_reg;
    assign result.pixel_color = out_data_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !rd_adv |=> rd_valid_reg && $stable(pal_q_reg))
        else $error("stalled palette read lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop without queue entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_adv |=> out_valid_reg)
        else $error("read stage advanced without output");
`endif

endmodule

FILE: rtl/core/noise_octave_pixel_blender.sv
// Noise octave pixel blender: each pixel transfer carries four main-octave
// corner texels, one texel each of the 2x and 4x octaves and the dither
// coordinates; it is interpolated, mixed, dithered, offset, clamped and looked
// up in a 256-entry RGB565 palette. A palette write transfer (func 0) loads
// one entry and returns nothing. The block takes one transfer per clock
// sustained while input ready is high: a three-stage multiplier pipeline
// feeds a QUEUE_DEPTH-entry queue, and a single-port palette with a
// registered read drives the output register; a pixel's result passes the
// stages, the queue and the palette read register into the output register.
// Input ready drops only when QUEUE_DEPTH items are in flight and not yet
// popped, which happens only while the output side stalls. Palette contents
// are undefined after reset until written; there is no clearing pass.
// Configuration writes are taken every cycle and must be made while idle.
module noise_octave_pixel_blender #(
    parameter int QUEUE_DEPTH = nopb_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    nopb_pix_if.sink    pixel,
    nopb_cfg_if.sink    cfg,
    nopb_out_if.source  result
);
    import nopb_pkg::*;

    logic   push;
    qitem_t push_item;
    logic   pop;
    logic   head_valid;
    qitem_t head_item;

    nopb_front #(
        .QDEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg       (cfg),
        .pop       (pop),
        .push      (push),
        .push_item (push_item)
    );

    nopb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    nopb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result     (result)
    );

endmodule

FILE: verif/tb_noise_octave_pixel_blender.sv
`timescale 1ns / 1ps

module tb_noise_octave_pixel_blender;
    import nopb_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_CYCLES  = 12;
    localparam int WRITE_PCT     = 15;

    // 8x8 ordered dither thresholds, row-major
    localparam int DITHER_MAP [64] = '{
         0, 32,  8, 40,  2, 34, 10, 42,
        48, 16, 56, 24, 50, 18, 58, 26,
        12, 44,  4, 36, 14, 46,  6, 38,
        60, 28, 52, 20, 62, 30, 54, 22,
         3, 35, 11, 43,  1, 33,  9, 41,
        51, 19, 59, 27, 49, 17, 57, 25,
        15, 47,  7, 39, 13, 45,  5, 37,
        63, 31, 55, 23, 61, 29, 53, 21
    };

    typedef struct {
        logic        func;
        logic [7:0]  tex_a00;
        logic [7:0]  tex_a01;
        logic [7:0]  tex_a10;
        logic [7:0]  tex_a11;
        logic [7:0]  tex_b;
        logic [7:0]  tex_c;
        logic [2:0]  dither_col;
        logic [2:0]  dither_row;
        logic [7:0]  pal_index;
        logic [15:0] pal_color;
    } pix_item_t;

    logic clk = 1'b0;
    logic rst_n;

    nopb_pix_if pix_bus ();
    nopb_cfg_if cfg_bus ();
    nopb_out_if out_bus ();

    noise_octave_pixel_blender DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_bus),
        .cfg    (cfg_bus),
        .result (out_bus)
    );

    // shadow of the block's registers and palette
    int frac_x   = 0;
    int frac_y   = 0;
    int weight_a = int'(WEIGHT_A_RESET);
    int weight_b = int'(WEIGHT_B_RESET);
    int density  = 0;
    logic [15:0] palette_shadow [256];
    bit          palette_loaded [256];

    pix_item_t   pixel_feed [$];
    logic [15:0] expected_colors [$];
    int pushed_count   = 0;
    int accepted_count = 0;
    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic pix_fire     = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int interp8(int p, int q, int f);
        return p + (((q - p) * f) >>> 8);
    endfunction

    // palette index that a pixel reads under the current register settings
    function automatic int blend_index(pix_item_t it);
        int va;
        int vb;
        int a;
        int d;
        int mix;
        int v;
        va  = interp8(int'(it.tex_a00), int'(it.tex_a01), frac_x);
        vb  = interp8(int'(it.tex_a10), int'(it.tex_a11), frac_x);
        a   = interp8(va, vb, frac_y) & 255;
        d   = (DITHER_MAP[{it.dither_row, it.dither_col}] - 31) / 4;
        mix = (a - int'(it.tex_c)) * weight_a + (int'(it.tex_b) - int'(it.tex_c)) * weight_b;
        v   = int'(it.tex_c) + (mix >>> 6) + d + density;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    function automatic pix_item_t pixel_item(int a00, int a01, int a10, int a11,
                                             int b, int c, int row, int col);
        pix_item_t it;
        it.func       = FUNC_PIXEL;
        it.tex_a00    = 8'(a00);
        it.tex_a01    = 8'(a01);
        it.tex_a10    = 8'(a10);
        it.tex_a11    = 8'(a11);
        it.tex_b      = 8'(b);
        it.tex_c      = 8'(c);
        it.dither_row = 3'(row);
        it.dither_col = 3'(col);
        it.pal_index  = 8'($urandom_range(255, 0));
        it.pal_color  = 16'($urandom_range(65535, 0));
        return it;
    endfunction

    function automatic pix_item_t palette_item(logic [7:0] idx, logic [15:0] color);
        pix_item_t it;
        it = pixel_item($urandom_range(255, 0), $urandom_range(255, 0),
                        $urandom_range(255, 0), $urandom_range(255, 0),
                        $urandom_range(255, 0), $urandom_range(255, 0),
                        $urandom_range(7, 0), $urandom_range(7, 0));
        it.func      = FUNC_WRITE;
        it.pal_index = idx;
        it.pal_color = color;
        return it;
    endfunction

    function automatic pix_item_t random_item();
        int lo;
        int hi;
        lo = 0;
        hi = 255;
        if ($urandom_range(99, 0) < WRITE_PCT)
            return palette_item(8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)));
        // bias some pixels to dark or bright texels to reach the clamps
        case ($urandom_range(9, 0))
            0: hi = 15;
            1: lo = 240;
            default: ;
        endcase
        return pixel_item($urandom_range(hi, lo), $urandom_range(hi, lo),
                          $urandom_range(hi, lo), $urandom_range(hi, lo),
                          $urandom_range(hi, lo), $urandom_range(hi, lo),
                          $urandom_range(7, 0), $urandom_range(7, 0));
    endfunction

    // queue an item; load the palette entry first if the pixel would read a blank one
    task automatic feed(pix_item_t it);
        pix_item_t fill;
        int idx;
        if (it.func == FUNC_PIXEL)
        begin
            idx = blend_index(it);
            if (!palette_loaded[8'(idx)])
            begin
                fill = palette_item(8'(idx), 16'($urandom_range(65535, 0)));
                palette_loaded[8'(idx)] = 1'b1;
                pixel_feed.push_back(fill);
                pushed_count++;
            end
        end
        else
            palette_loaded[it.pal_index] = 1'b1;
        pixel_feed.push_back(it);
        pushed_count++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != pushed_count || expected_colors.size() != 0);
        // let trailing palette writes settle
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic program_phase(int p);
        int fx;
        int fy;
        int wa;
        int wb;
        int dens;
        case (p)
            0: begin fx = 0;   fy = 0;   wa = 64;  wb = 0;   dens = -55; end
            1: begin fx = 255; fy = 255; wa = 127; wb = 127; dens = 55;  end
            2: begin fx = 255; fy = 0;   wa = 0;   wb = 64;  dens = 0;   end
            3: begin fx = 0;   fy = 255; wa = 0;   wb = 0;   dens = -55; end
            default:
            begin
                fx   = $urandom_range(255, 0);
                fy   = $urandom_range(255, 0);
                wa   = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 0)
                                                   : $urandom_range(64, 0);
                wb   = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 0)
                                                   : $urandom_range(64 - (wa % 65), 0);
                dens = int'($urandom_range(110, 0)) - 55;
            end
        endcase
        set_reg(CFG_FRAC_X, CFG_DATA_W'(fx));
        set_reg(CFG_FRAC_Y, CFG_DATA_W'(fy));
        set_reg(CFG_WEIGHT_A, CFG_DATA_W'(wa));
        set_reg(CFG_WEIGHT_B, CFG_DATA_W'(wb));
        set_reg(CFG_DENSITY_OFFSET, CFG_DATA_W'(dens));
        // indexes past the last register must be dropped
        if (p % 6 == 0)
            for (int k = CFG_DENSITY_OFFSET + 1; k < (1 << CFG_INDEX_W); k++)
                set_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom_range(255, 0)));
    endtask

    // driver: present items from the feed, hold until transfer
    always @(negedge clk)
    begin
        pix_item_t nxt;
        if (rst_n)
        begin
            if (!pix_bus.valid || pix_fire)
            begin
                if (pixel_feed.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    nxt = pixel_feed.pop_front();
                    pix_bus.func       <= nxt.func;
                    pix_bus.tex_a00    <= nxt.tex_a00;
                    pix_bus.tex_a01    <= nxt.tex_a01;
                    pix_bus.tex_a10    <= nxt.tex_a10;
                    pix_bus.tex_a11    <= nxt.tex_a11;
                    pix_bus.tex_b      <= nxt.tex_b;
                    pix_bus.tex_c      <= nxt.tex_c;
                    pix_bus.dither_col <= nxt.dither_col;
                    pix_bus.dither_row <= nxt.dither_row;
                    pix_bus.pal_index  <= nxt.pal_index;
                    pix_bus.pal_color  <= nxt.pal_color;
                    pix_bus.valid      <= 1'b1;
                end
                else
                    pix_bus.valid <= 1'b0;
            end
            out_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        pix_item_t seen;
        logic [15:0] want;
        if (!rst_n)
            pix_fire <= 1'b0;
        else
        begin
            pix_fire <= pix_bus.valid && pix_bus.ready;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    CFG_FRAC_X:         frac_x   = int'(cfg_bus.data);
                    CFG_FRAC_Y:         frac_y   = int'(cfg_bus.data);
                    CFG_WEIGHT_A:       weight_a = int'(cfg_bus.data[6:0]);
                    CFG_WEIGHT_B:       weight_b = int'(cfg_bus.data[6:0]);
                    CFG_DENSITY_OFFSET: density  = int'($signed(cfg_bus.data[6:0]));
                    default: ;
                endcase
            end
            if (pix_bus.valid && pix_bus.ready)
            begin
                seen.func       = pix_bus.func;
                seen.tex_a00    = pix_bus.tex_a00;
                seen.tex_a01    = pix_bus.tex_a01;
                seen.tex_a10    = pix_bus.tex_a10;
                seen.tex_a11    = pix_bus.tex_a11;
                seen.tex_b      = pix_bus.tex_b;
                seen.tex_c      = pix_bus.tex_c;
                seen.dither_col = pix_bus.dither_col;
                seen.dither_row = pix_bus.dither_row;
                seen.pal_index  = pix_bus.pal_index;
                seen.pal_color  = pix_bus.pal_color;
                accepted_count++;
                if (seen.func == FUNC_WRITE)
                    palette_shadow[seen.pal_index] = seen.pal_color;
                else
                    expected_colors.push_back(palette_shadow[8'(blend_index(seen))]);
            end
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("pixel_color: got %h with no pixel outstanding",
                           out_bus.pixel_color);
                    err_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (out_bus.pixel_color !== want)
                    begin
                        $error("pixel_color: expected %h, got %h", want, out_bus.pixel_color);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #(3_000_000);
        $display("noise_octave_pixel_blender verification failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        pix_bus.valid      = 1'b0;
        pix_bus.func       = FUNC_WRITE;
        pix_bus.tex_a00    = '0;
        pix_bus.tex_a01    = '0;
        pix_bus.tex_a10    = '0;
        pix_bus.tex_a11    = '0;
        pix_bus.tex_b      = '0;
        pix_bus.tex_c      = '0;
        pix_bus.dither_col = '0;
        pix_bus.dither_row = '0;
        pix_bus.pal_index  = '0;
        pix_bus.pal_color  = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_FRAC_X;
        cfg_bus.data       = '0;
        out_bus.ready      = 1'b0;
        send_idle_pct      = 22;
        recv_stall_pct     = 59;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pixels under reset settings
        feed(palette_item(8'd0, 16'h0000));
        feed(palette_item(8'd255, 16'hFFFF));
        feed(palette_item(8'hAA, 16'h5555));
        feed(palette_item(8'h55, 16'hAAAA));
        feed(pixel_item(0, 0, 0, 0, 0, 0, 0, 0));             // clamps low
        feed(pixel_item(255, 255, 255, 255, 255, 255, 7, 0)); // clamps high
        feed(pixel_item(255, 0, 0, 0, 0, 0, 7, 7));
        feed(pixel_item(0, 255, 255, 0, 255, 0, 3, 1));       // dither truncates to zero
        feed(pixel_item(10, 20, 30, 40, 50, 60, 5, 3));
        feed(pixel_item(0, 0, 0, 0, 0, 200, 4, 4));           // negative mix floors
        feed(pixel_item(128, 127, 1, 254, 85, 170, 2, 6));
        feed(palette_item(8'hAA, 16'h1234));                  // overwrite entry 0xAA
        feed(pixel_item(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 0, 2));

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // drain fully before touching registers
            wait_drained();
            program_phase(p);
            if (p < RANDOM_PHASES / 3)
            begin
                send_idle_pct  = 22;
                recv_stall_pct = 59;
            end
            else if (p < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct  = 59;
                recv_stall_pct = 22;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                feed(random_item());
        end

        wait_drained();
        if (err_count == 0)
            $display("noise_octave_pixel_blender verification clean");
        else
            $display("noise_octave_pixel_blender verification failed");
        $finish;
    end

endmodule
